// ----- design/dary_max_heap_queue_defines.svh -----
// assertion helpers for the heap queue, clocked on clk and quiet while rst_n is low
`ifndef DARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define DARY_MAX_HEAP_QUEUE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define DMHQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define DMHQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/dmhq_pkg.sv -----
package dmhq_pkg;

  localparam int unsigned PRI_W     = 32;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_O_W = 9;

  // operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } entry_t;

endpackage

// ----- design/dary_max_heap_queue.sv -----
// d-ary max-heap priority queue. Pulse start while busy is low to hand over one beat:
// in_operation selects insert (0) or extract of the highest-priority entry (1). Every
// accepted beat yields exactly one result beat, shown for one cycle with out_strobe high;
// the receiver cannot stall, so it must take the result in that cycle. A rejected beat
// (insert when full, extract when empty) answers in the next cycle. An insert climbs one
// level per pass through compute-parent, read-parent and compare; it answers on reaching
// the root or from the compare where it stops below the root. An extract reads the root,
// then the last entry, and answers there if it took the only entry; otherwise each level
// of descent computes the child range, reads every child in turn, and then moves the best
// child up or drops the entry in. It answers on reaching a leaf or from that decision when
// it stops above a leaf. The walk is set by the single heap memory: one registered read
// per cycle. At the default ARITY of 4 with 256 entries an extract sinks at most four
// levels and an insert climbs at most four. Ties never move an entry; among tied children
// the lowest index wins.
// The heap memory needs no clearing after reset; only entries below the count held before the operation are read.
module dary_max_heap_queue #(
  parameter int unsigned ARITY    = 4,
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [dmhq_pkg::PRI_W-1:0]          in_priority_req,
  input  logic [dmhq_pkg::PAY_W-1:0]          in_payload,
  output logic                                out_strobe,
  output logic [dmhq_pkg::STATUS_W-1:0]       out_status,
  output logic [dmhq_pkg::PRI_W-1:0]          out_priority,
  output logic [dmhq_pkg::PAY_W-1:0]          out_payload,
  output logic [dmhq_pkg::COUNT_O_W-1:0]      out_entry_count
);

`include "dary_max_heap_queue_defines.svh"

  // index and count widths
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned ALOG = $clog2(ARITY);
  localparam int unsigned FW   = AW + ALOG + 1;          // first-child index
  // parent = (pos-1)/ARITY as a multiply by a rounded-up reciprocal, exact for AW-bit input
  localparam int unsigned DIV_S  = AW + ALOG;
  localparam int unsigned DIV_M  = ((1 << DIV_S) + ARITY - 1) / ARITY;
  localparam int unsigned PW     = 2 * AW + ALOG + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_IDX  = 4'd1;  // compute parent of the hole
  localparam logic [3:0] S_UP_RD   = 4'd2;  // read parent
  localparam logic [3:0] S_UP_CMP  = 4'd3;  // move parent down or drop the new entry in
  localparam logic [3:0] S_EX_ROOT = 4'd4;  // root data back, read last entry
  localparam logic [3:0] S_EX_LAST = 4'd5;  // last entry back, start descent
  localparam logic [3:0] S_DN_IDX  = 4'd6;  // compute child range
  localparam logic [3:0] S_DN_SCAN = 4'd7;  // stream children, track the best one
  localparam logic [3:0] S_DN_DEC  = 4'd8;  // move best child up or drop the entry in

  // heap memory, one write and one registered read per cycle
  dmhq_pkg::entry_t heap_mem [CAPACITY];
  dmhq_pkg::entry_t rdata_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  dmhq_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= heap_mem[rd_addr];
    end
  end

  // control state
  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            strobe_r, strobe_nxt;
  logic            pend_r, pend_nxt;         // a child read is in flight
  logic            best_vld_r, best_vld_nxt;

  // working registers
  dmhq_pkg::entry_t               cur_r, cur_nxt;      // entry looking for its slot
  logic [AW-1:0]                  pos_r, pos_nxt;      // current hole
  logic [AW-1:0]                  parent_r, parent_nxt;
  logic [CW-1:0]                  issue_r, issue_nxt;  // next child to read
  logic [CW-1:0]                  last_r, last_nxt;    // one past the last child
  logic [AW-1:0]                  pend_idx_r, pend_idx_nxt;
  dmhq_pkg::entry_t               best_r, best_nxt;
  logic [AW-1:0]                  best_idx_r, best_idx_nxt;
  logic [dmhq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [dmhq_pkg::PRI_W-1:0]     res_pri_r, res_pri_nxt;
  logic [dmhq_pkg::PAY_W-1:0]     res_pay_r, res_pay_nxt;

  // index arithmetic
  logic [AW-1:0] pos_m1;
  logic [PW-1:0] div_prod;
  logic [FW-1:0] first_idx;
  logic [FW:0]   range_end;

  assign pos_m1    = pos_r - AW'(1);
  assign div_prod  = PW'(pos_m1) * PW'(DIV_M);
  assign first_idx = FW'(pos_r) * FW'(ARITY) + FW'(1);
  assign range_end = (FW + 1)'(first_idx) + (FW + 1)'(ARITY);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    strobe_nxt   = 1'b0;
    pend_nxt     = pend_r;
    best_vld_nxt = best_vld_r;
    cur_nxt      = cur_r;
    pos_nxt      = pos_r;
    parent_nxt   = parent_r;
    issue_nxt    = issue_r;
    last_nxt     = last_r;
    pend_idx_nxt = pend_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    status_nxt   = status_r;
    res_pri_nxt  = res_pri_r;
    res_pay_nxt  = res_pay_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == dmhq_pkg::OP_INSERT) begin
            res_pri_nxt = '0;
            res_pay_nxt = '0;
            if (count_r >= CW'(CAPACITY)) begin
              // full: answer at once, nothing changes
              strobe_nxt = 1'b1;
              status_nxt = dmhq_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              cur_nxt   = '{pri: in_priority_req, pay: in_payload};
              pos_nxt   = count_r[AW-1:0];
              state_nxt = S_UP_IDX;
            end
          end else begin
            if (count_r == '0) begin
              // empty: answer at once, nothing changes
              strobe_nxt  = 1'b1;
              status_nxt  = dmhq_pkg::ST_EMPTY;
              res_pri_nxt = '0;
              res_pay_nxt = '0;
            end else begin
              count_nxt = count_r - CW'(1);
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_EX_ROOT;
            end
          end
        end
      end

      S_UP_IDX: begin
        if (pos_r == '0) begin
          wr_en      = 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = dmhq_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end else begin
          parent_nxt = div_prod[DIV_S +: AW];
          state_nxt  = S_UP_RD;
        end
      end

      S_UP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = parent_r;
        state_nxt = S_UP_CMP;
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rdata_r.pri < cur_r.pri) begin
          // parent moves down into the hole
          wr_data   = rdata_r;
          pos_nxt   = parent_r;
          state_nxt = S_UP_IDX;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = dmhq_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end
      end

      S_EX_ROOT: begin
        res_pri_nxt = rdata_r.pri;
        res_pay_nxt = rdata_r.pay;
        rd_en       = 1'b1;
        rd_addr     = count_r[AW-1:0];   // old last entry
        state_nxt   = S_EX_LAST;
      end

      S_EX_LAST: begin
        cur_nxt = rdata_r;
        if (count_r == '0) begin
          // took the only entry, no descent
          strobe_nxt = 1'b1;
          status_nxt = dmhq_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end else begin
          pos_nxt   = '0;
          state_nxt = S_DN_IDX;
        end
      end

      S_DN_IDX: begin
        if (first_idx >= FW'(count_r)) begin
          // leaf: entry settles here
          wr_en      = 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = dmhq_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end else begin
          issue_nxt    = first_idx[CW-1:0];
          last_nxt     = (range_end > (FW + 1)'(count_r)) ? count_r : range_end[CW-1:0];
          pend_nxt     = 1'b0;
          best_vld_nxt = 1'b0;
          state_nxt    = S_DN_SCAN;
        end
      end

      S_DN_SCAN: begin
        if (issue_r < last_r) begin
          rd_en        = 1'b1;
          rd_addr      = issue_r[AW-1:0];
          issue_nxt    = issue_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[AW-1:0];
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DN_DEC;
        end
        // strictly greater replaces, so the first of tied children stays
        if (pend_r && (!best_vld_r || (rdata_r.pri > best_r.pri))) begin
          best_nxt     = rdata_r;
          best_idx_nxt = pend_idx_r;
          best_vld_nxt = 1'b1;
        end
      end

      S_DN_DEC: begin
        wr_en = 1'b1;
        if (best_r.pri > cur_r.pri) begin
          // best child moves up into the hole
          wr_data   = best_r;
          pos_nxt   = best_idx_r;
          state_nxt = S_DN_IDX;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = dmhq_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      strobe_r   <= 1'b0;
      pend_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      strobe_r   <= strobe_nxt;
      pend_r     <= pend_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    parent_r   <= parent_nxt;
    issue_r    <= issue_nxt;
    last_r     <= last_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    status_r   <= status_nxt;
    res_pri_r  <= res_pri_nxt;
    res_pay_r  <= res_pay_nxt;
  end

  // count reported masked to the result field width
  logic [31:0] count_ext;
  assign count_ext = 32'(count_r);

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_priority    = res_pri_r;
  assign out_payload     = res_pay_r;
  assign out_entry_count = count_ext[dmhq_pkg::COUNT_O_W-1:0];

  `DMHQ_ASSERT_ALWAYS(a_count_max, count_r <= CW'(CAPACITY), "entry count above capacity")
  `DMHQ_ASSERT_ALWAYS(a_wr_in_range, wr_en |-> (CW'(wr_addr) < count_r), "write beyond held entries")
  `DMHQ_ASSERT_ALWAYS(a_scan_in_range, (state_r == S_DN_SCAN && rd_en) |-> (CW'(rd_addr) < count_r), "child read beyond held entries")
  `DMHQ_ASSERT_ALWAYS(a_accept_answer, (start && !busy) |=> (out_strobe || busy), "accepted beat neither answered nor in work")
  `DMHQ_ASSERT_ALWAYS(a_full_reject, (out_strobe && out_status == dmhq_pkg::ST_FULL) |-> (count_r == CW'(CAPACITY)), "full status while not full")

endmodule
